// ===== src/vte_pkg.sv =====
// shared types and constants for the vertex transform engine
`default_nettype none

package vte_pkg;

   localparam int VTE_FRAC_BITS = 16;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int ACC_W         = PROD_W + 2;
   localparam int N_LANES       = 4;
   localparam int N_ELEMS       = N_LANES * N_LANES;
   localparam int MODE_W        = 2;
   localparam int IDX_W         = 4;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIR   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FULL  = 2'd3;

   // stage enables handed to every lane
   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } lane_ctrl_type;

   // one lane's finished component
   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic              sat;
   } lane_out_type;

endpackage

`default_nettype wire

// ===== src/vertex_transform_engine_top.sv =====
// top level of the homogeneous 4x4 vertex transform engine
//
// req channel: one beat per command. tuser carries the mode: load one matrix
// element, transform a point (w taken as one), a direction (upper 3x3 only)
// or a full four-component vector. A load beat updates the matrix at once
// and produces no rsp beat; the next beat already sees the new element.
// rsp channel: one beat per transform, x/y/z/w in tdata and the saturation
// flag in tuser. w is zero for point and direction transforms.
// path: a transform passes the product stage, the sum stage and the output
// register in that order before rsp_tvalid rises; rsp back-pressure can hold
// it in any of them.
// throughput: one beat per cycle while the rsp side takes its beats, set by the
// four column lanes of four multipliers each that all work in the same cycle.
// stall: each stage has its own valid bit and is loaded when it is empty or
// moving on, so while the rsp beat waits the earlier stages keep filling;
// req_tready falls only when all three stages hold beats.
// reset: synchronous, clears all valid bits and sets the matrix to identity.
`default_nettype none

module vertex_transform_engine_top #(
   parameter int FRAC_BITS = vte_pkg::VTE_FRAC_BITS
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [3:0] elem_index, [35:4] elem_value, [67:36] in_x, [99:68] in_y,
   // [131:100] in_z, [163:132] in_w, [167:164] zero
   input  wire  [167:0] req_tdata,
   // [1:0] mode
   input  wire  [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
   output logic [127:0] rsp_tdata,
   // [0] saturated
   output logic [0:0]   rsp_tuser
);

   localparam int DW = vte_pkg::DATA_W;
   localparam int NL = vte_pkg::N_LANES;
   localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   // request fields
   logic [vte_pkg::MODE_W-1:0] mode;
   logic [vte_pkg::IDX_W-1:0]  elem_index;
   logic [DW-1:0]              elem_value;
   logic signed [DW-1:0]       vec [NL];
   logic signed [DW-1:0]       w_row;

   assign mode       = req_tuser;
   assign elem_index = req_tdata[3:0];
   assign elem_value = req_tdata[35:4];
   assign vec[0]     = req_tdata[67:36];
   assign vec[1]     = req_tdata[99:68];
   assign vec[2]     = req_tdata[131:100];
   assign vec[3]     = w_row;

   // the fourth input row: w itself, one for a point, nothing for a direction
   always_comb begin
      case (mode)
         vte_pkg::MODE_FULL:  w_row = req_tdata[163:132];
         vte_pkg::MODE_POINT: w_row = ONE;
         default:             w_row = '0;
      endcase
   end

   logic accept;
   logic is_load;
   assign accept  = req_tvalid && req_tready;
   assign is_load = (mode == vte_pkg::MODE_LOAD);

   // matrix, row-major, each element read at its fixed lane position
   logic [DW-1:0] matrix_ff [vte_pkg::N_ELEMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < vte_pkg::N_ELEMS; e++) begin
            matrix_ff[e] <= (e % (NL + 1) == 0) ? ONE : '0;
         end
      end else if (accept && is_load) begin
         matrix_ff[elem_index] <= elem_value;
      end
   end

   // pipeline valid bits and the full-product marker per stage
   logic prod_valid_ff, prod_valid_in;
   logic sum_valid_ff,  sum_valid_in;
   logic prod_full_ff,  sum_full_ff;
   logic prod_ready, sum_ready, merge_ready;

   assign sum_ready  = !sum_valid_ff || merge_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign req_tready = prod_ready;

   assign prod_valid_in = prod_ready ? (accept && !is_load) : prod_valid_ff;
   assign sum_valid_in  = sum_ready ? prod_valid_ff : sum_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         prod_full_ff <= (mode == vte_pkg::MODE_FULL);
      end
      if (sum_ready) begin
         sum_full_ff <= prod_full_ff;
      end
   end

   vte_pkg::lane_ctrl_type lane_ctrl;
   assign lane_ctrl.prod_en = prod_ready;
   assign lane_ctrl.sum_en  = sum_ready;

   vte_pkg::lane_out_type lane_res [NL];

   // one lane per output column
   for (genvar j = 0; j < NL; j++) begin : g_lane
      logic signed [DW-1:0] col [NL];
      for (genvar i = 0; i < NL; i++) begin : g_col
         assign col[i] = matrix_ff[i*NL + j];
      end

      vte_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .vec      (vec),
         .col      (col),
         .lane_out (lane_res[j])
      );
   end

   vte_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid_ff),
      .in_full   (sum_full_ff),
      .lanes     (lane_res),
      .in_ready  (merge_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_sat   (rsp_tuser[0])
   );

endmodule

`default_nettype wire

// ===== src/vte_lane.sv =====
// one output column: four products, a full-width sum, floor shift and saturation
`default_nettype none

module vte_lane #(
   parameter int FRAC_BITS = vte_pkg::VTE_FRAC_BITS
) (
   input  wire                            clock,
   input  wire vte_pkg::lane_ctrl_type    ctrl,
   input  wire logic signed [vte_pkg::DATA_W-1:0] vec [vte_pkg::N_LANES],
   input  wire logic signed [vte_pkg::DATA_W-1:0] col [vte_pkg::N_LANES],
   output vte_pkg::lane_out_type          lane_out
);

   logic signed [vte_pkg::PROD_W-1:0] prod_ff [vte_pkg::N_LANES];
   logic signed [vte_pkg::ACC_W-1:0]  sum_ff;
   logic signed [vte_pkg::ACC_W-1:0]  sum_in;
   logic signed [vte_pkg::ACC_W-1:0]  shifted;
   logic                              in_range;

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         for (int k = 0; k < vte_pkg::N_LANES; k++) begin
            prod_ff[k] <= vec[k] * col[k];
         end
      end
      if (ctrl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < vte_pkg::N_LANES; k++) begin
         sum_in = sum_in + vte_pkg::ACC_W'(prod_ff[k]);
      end
   end

   // floor shift back to the fixed-point grid
   assign shifted  = sum_ff >>> FRAC_BITS;
   assign in_range = (&shifted[vte_pkg::ACC_W-1:vte_pkg::DATA_W-1]) ||
                     !(|shifted[vte_pkg::ACC_W-1:vte_pkg::DATA_W-1]);

   always_comb begin
      lane_out.sat = !in_range;
      if (in_range) begin
         lane_out.res = shifted[vte_pkg::DATA_W-1:0];
      end else if (shifted[vte_pkg::ACC_W-1]) begin
         lane_out.res = {1'b1, {(vte_pkg::DATA_W-1){1'b0}}};
      end else begin
         lane_out.res = {1'b0, {(vte_pkg::DATA_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

// ===== src/vte_merge.sv =====
// gathers x/y/z (w too if full) into the output register and flags saturation
`default_nettype none

module vte_merge (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  wire                          in_full,
   input  wire vte_pkg::lane_out_type   lanes [vte_pkg::N_LANES],
   output logic                         in_ready,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [vte_pkg::N_LANES*vte_pkg::DATA_W-1:0] out_data,
   output logic                         out_sat
);

   logic                                          valid_ff;
   logic                                          valid_in;
   logic [vte_pkg::N_LANES*vte_pkg::DATA_W-1:0]   data_ff;
   logic [vte_pkg::N_LANES*vte_pkg::DATA_W-1:0]   data_in;
   logic                                          sat_ff;
   logic                                          sat_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      sat_in  = 1'b0;
      data_in = '0;
      for (int j = 0; j < vte_pkg::N_LANES - 1; j++) begin
         data_in[j*vte_pkg::DATA_W +: vte_pkg::DATA_W] = lanes[j].res;
         sat_in = sat_in | lanes[j].sat;
      end
      // w is only produced by the full homogeneous product
      if (in_full) begin
         data_in[(vte_pkg::N_LANES-1)*vte_pkg::DATA_W +: vte_pkg::DATA_W] =
            lanes[vte_pkg::N_LANES-1].res;
         sat_in = sat_in | lanes[vte_pkg::N_LANES-1].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

// ===== tb/tb_vertex_transform_engine_top.sv =====
// self-checking bench for the vertex transform engine: own matrix predictor, random stalls
module tb_vertex_transform_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;   // far above the slowest legal run
   localparam int N_RANDOM     = 2000;
   localparam int HOLD_AT      = 300;      // rsp beat count at which the long hold starts
   localparam int LONG_HOLD    = 250;      // cycles with rsp_tready low
   localparam int DRAIN        = 20;       // quiet cycles after the last expected beat

   // one transformed vertex as it leaves the block
   typedef struct packed {
      logic [127:0] comps;   // x in the low word up to w
      logic         sat;
   } vertex_result_type;

   // keeps a private copy of the matrix and the vertices still owed by the block
   class scoreboard_type;
      logic signed [vte_pkg::DATA_W-1:0] matrix [vte_pkg::N_ELEMS];
      vertex_result_type expected_vertices [$];
      int mismatches;
      int loads;
      int transforms;
      int clamped;

      function new();
         for (int k = 0; k < vte_pkg::N_ELEMS; k++) begin
            matrix[k] = (k % 5 == 0) ? (1 << vte_pkg::VTE_FRAC_BITS) : 0;
         end
      endfunction

      // accepted req beat: update the matrix or queue the predicted vertex
      function void note_command(logic [vte_pkg::MODE_W-1:0] mode, logic [167:0] data);
         logic signed [vte_pkg::DATA_W-1:0] vec [vte_pkg::N_LANES];
         logic signed [79:0] acc;
         logic signed [79:0] shifted;
         vertex_result_type res;
         int rows;
         if (mode == vte_pkg::MODE_LOAD) begin
            matrix[data[3:0]] = data[35:4];
            loads++;
            return;
         end
         vec[0] = data[67:36];
         vec[1] = data[99:68];
         vec[2] = data[131:100];
         vec[3] = data[163:132];
         rows = (mode == vte_pkg::MODE_FULL) ? 4 : 3;
         res = '0;
         for (int j = 0; j < vte_pkg::N_LANES; j++) begin
            if (j == 3 && mode != vte_pkg::MODE_FULL) continue;
            acc = '0;
            for (int i = 0; i < rows; i++) begin
               acc = acc + longint'(vec[i]) * longint'(matrix[i * 4 + j]);
            end
            if (mode == vte_pkg::MODE_POINT) begin
               acc = acc + (longint'(matrix[12 + j]) <<< vte_pkg::VTE_FRAC_BITS);
            end
            shifted = acc >>> vte_pkg::VTE_FRAC_BITS;
            if (shifted > 80'sd2147483647) begin
               res.comps[j * 32 +: 32] = 32'h7FFF_FFFF;
               res.sat = 1'b1;
            end else if (shifted < -80'sd2147483648) begin
               res.comps[j * 32 +: 32] = 32'h8000_0000;
               res.sat = 1'b1;
            end else begin
               res.comps[j * 32 +: 32] = shifted[31:0];
            end
         end
         transforms++;
         if (res.sat) clamped++;
         expected_vertices.push_back(res);
      endfunction

      // accepted rsp beat against the oldest predicted vertex
      function void check_vertex(logic [127:0] data, logic [0:0] user);
         vertex_result_type want;
         bit bad;
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat x=%h y=%h z=%h w=%h sat=%b",
                        data[31:0], data[63:32], data[95:64], data[127:96], user[0]);
            return;
         end
         want = expected_vertices.pop_front();
         bad = (want.sat !== user[0]);
         for (int j = 0; j < vte_pkg::N_LANES; j++) begin
            if (want.comps[j * 32 +: 32] !== data[j * 32 +: 32]) bad = 1'b1;
         end
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"vertex mismatch: expected x=%h y=%h z=%h w=%h sat=%b, ",
                         "got x=%h y=%h z=%h w=%h sat=%b"},
                        want.comps[31:0], want.comps[63:32], want.comps[95:64],
                        want.comps[127:96], want.sat, data[31:0], data[63:32],
                        data[95:64], data[127:96], user[0]);
         end
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [167:0]  req_tdata = '0;   // [3:0] idx, [35:4] value, then x, y, z, w, 4 zero bits
   logic [1:0]    req_tuser = vte_pkg::MODE_LOAD;   // [1:0] mode
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;        // [31:0] x, [63:32] y, [95:64] z, [127:96] w
   logic [0:0]    rsp_tuser;        // [0] saturated

   int unsigned    cycles = 0;
   int             sent = 0;
   int             rsp_beats = 0;
   scoreboard_type scoreboard = new();

   // the three transform modes, drawn at random
   logic [vte_pkg::MODE_W-1:0] xform_modes [3] =
      '{vte_pkg::MODE_POINT, vte_pkg::MODE_DIR, vte_pkg::MODE_FULL};

   vertex_transform_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // cycle limit and beat monitor, sampled at the rising edge before any update lands
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d vertices still owed", cycles,
                  scoreboard.pending());
         $display("tb_vertex_transform_engine_top NOT OK");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) scoreboard.note_command(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) scoreboard.check_vertex(rsp_tdata, rsp_tuser);
      end
   end

   // idle cycles for the n-th beat: every third stretch of 64 beats runs without gaps
   function automatic int idle_cycles(int n);
      return ((n / 64) % 3 == 0) ? 0 : $urandom_range(0, 18);
   endfunction

   // req tdata layout, first field lowest
   function automatic logic [167:0] req_word(logic [3:0] idx, logic [31:0] val,
                                             logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z, logic [31:0] w);
      return {4'b0, w, z, y, x, val, idx};
   endfunction

   // q16.16 operand: mix of raw words, small and medium values and corners
   function automatic logic [31:0] rand_q16();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;   // about +-4.0
         2: begin
            case ($urandom_range(0, 4))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 0;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0001_0000;
            endcase
         end
         default: v = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;  // about +-256.0
      endcase
      return v;
   endfunction

   // offer one req beat after a random gap and hold it until taken
   task automatic send_beat(logic [vte_pkg::MODE_W-1:0] mode, logic [167:0] data);
      int gap;
      gap = idle_cycles(sent);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= mode;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // rsp side: random stalls per beat, one long hold so the pipe fills and req stalls
   task automatic receive_loop();
      int stall;
      forever begin
         stall = (rsp_beats == HOLD_AT) ? LONG_HOLD : idle_cycles(rsp_beats + 32);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_beats++;
      end
   endtask

   task automatic run_directed();
      // identity after reset, all three transform kinds
      send_beat(vte_pkg::MODE_POINT, req_word(4'd0, 32'd0, 32'h0001_0000, 32'h0002_0000,
                                              32'hFFFD_0000, 32'h1234_5678));
      send_beat(vte_pkg::MODE_DIR, req_word(4'd0, 32'd0, 32'h0001_0000, 32'h0002_0000,
                                            32'hFFFD_0000, 32'h1234_5678));
      send_beat(vte_pkg::MODE_FULL, req_word(4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                             32'h8000_0000, 32'h0, 32'hFFFF_FFFF));
      // loads ignore the vector fields; translation row at the extremes
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd12, 32'h000A_0000, '1, '1, '1, '1));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd13, 32'h8000_0000, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd14, 32'h7FFF_FFFF, '1, '0, '1, '0));
      // translation reaches points only, w unused there
      send_beat(vte_pkg::MODE_POINT, req_word(4'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                              32'h7FFF_FFFF));
      // translation pushes every component past the range
      send_beat(vte_pkg::MODE_POINT, req_word(4'd0, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                              32'h0001_0000, 32'd0));
      send_beat(vte_pkg::MODE_DIR, req_word(4'd0, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                            32'h0001_0000, 32'd0));
      // half-unit element: the shift rounds toward minus infinity
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd5, 32'h0000_8000, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_DIR, req_word(4'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0));
      send_beat(vte_pkg::MODE_DIR, req_word(4'd0, 32'd0, '1, '1, '1, 32'd0));
      // largest magnitudes in every row, both signs
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd0, 32'h7FFF_FFFF, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd4, 32'h7FFF_FFFF, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd8, 32'h7FFF_FFFF, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd3, 32'h8000_0000, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd7, 32'h8000_0000, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd11, 32'h8000_0000, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_LOAD, req_word(4'd15, 32'h8000_0000, '0, '0, '0, '0));
      send_beat(vte_pkg::MODE_FULL, req_word(4'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                             32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_beat(vte_pkg::MODE_FULL, req_word(4'd0, 32'd0, 32'h8000_0000, 32'h8000_0000,
                                             32'h8000_0000, 32'h8000_0000));
      // most negative times most negative overflows positive
      send_beat(vte_pkg::MODE_FULL, req_word(4'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0,
                                             32'd0));
   endtask

   task automatic run_random();
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 3) == 0)
            send_beat(vte_pkg::MODE_LOAD, req_word(4'($urandom_range(0, 15)), rand_q16(),
                                                   $urandom, $urandom, $urandom, $urandom));
         else
            send_beat(xform_modes[$urandom_range(0, 2)],
                      req_word(4'($urandom_range(0, 15)), $urandom, rand_q16(), rand_q16(),
                               rand_q16(), rand_q16()));
      end
   endtask

   initial begin
      // reset held first, then both sides start
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_loop();
      join_none
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      // let the monitor see the last req beat, then drain
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("run: %0d req beats, %0d matrix loads, %0d transforms (%0d clamped)",
               sent, scoreboard.loads, scoreboard.transforms, scoreboard.clamped);
      $display("rsp side held off for %0d cycles once; %0d mismatches", LONG_HOLD,
               scoreboard.mismatches);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("tb_vertex_transform_engine_top OK");
      end else begin
         $display("tb_vertex_transform_engine_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/vte_pkg.sv
src/vte_lane.sv
src/vte_merge.sv
src/vertex_transform_engine_top.sv
tb/tb_vertex_transform_engine_top.sv
